### sv/serial_command_line_parser_assert.svh
// Assertion macros shared by the parser RTL.
`ifndef SERIAL_COMMAND_LINE_PARSER_ASSERT_SVH
`define SERIAL_COMMAND_LINE_PARSER_ASSERT_SVH

// Check a condition at every clock edge outside reset.
`define SCLP_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Check that the consequent holds in the same cycle as the antecedent.
`define SCLP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define SCLP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/sclp_pkg.sv
`timescale 1ns / 1ps

package sclp_pkg;

  localparam int unsigned LINE_MAX = 64;
  localparam int unsigned CNT_W = $clog2(LINE_MAX);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(LINE_MAX - 1);

  localparam logic [3:0] PH_LEAD      = 4'd0;
  localparam logic [3:0] PH_HELP      = 4'd1;
  localparam logic [3:0] PH_ADDR_SP   = 4'd2;
  localparam logic [3:0] PH_ADDR_SIGN = 4'd3;
  localparam logic [3:0] PH_ADDR_DIG  = 4'd4;
  localparam logic [3:0] PH_NOADDR    = 4'd5;
  localparam logic [3:0] PH_ARG_SP    = 4'd6;
  localparam logic [3:0] PH_ARG_SIGN  = 4'd7;
  localparam logic [3:0] PH_ARG_INT   = 4'd8;
  localparam logic [3:0] PH_ARG_FRAC  = 4'd9;
  localparam logic [3:0] PH_ARG_DONE  = 4'd10;
  localparam logic [3:0] PH_NOARG     = 4'd11;
  localparam logic [3:0] PH_EMPTY     = 4'd12;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_HELP      = 3'd1;
  localparam logic [2:0] ST_MISS_ADDR = 3'd2;
  localparam logic [2:0] ST_MISS_ARG  = 3'd3;
  localparam logic [2:0] ST_UNKNOWN   = 3'd4;

  localparam logic [1:0] CFG_IDLE_FLUSH  = 2'd0;
  localparam logic [1:0] CFG_LOWER_LIMIT = 2'd1;
  localparam logic [1:0] CFG_UPPER_LIMIT = 2'd2;

  localparam logic [15:0] IDLE_FLUSH_RST  = 16'd200;
  localparam logic [15:0] LOWER_LIMIT_RST = 16'd3000;
  localparam logic [15:0] UPPER_LIMIT_RST = 16'd286;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_HELP  = 8'h3F;
  localparam logic [7:0] CH_UP_V  = 8'h56;
  localparam logic [7:0] CH_LO_V  = 8'h76;

  // Fraction kept as 4-digit decimal d; d * 65536 / 10000 = (d * FRAC_RECIP) >> FRAC_SHIFT.
  localparam int unsigned FRAC_W = 14;
  localparam logic [26:0] FRAC_RECIP = 27'd109951163;
  localparam int unsigned FRAC_SHIFT = 24;
  localparam int unsigned PROD_W = FRAC_W + 27;

  function automatic logic [31:0] mul10_add(input logic [31:0] acc, input logic [3:0] dig);
    mul10_add = (acc << 3) + (acc << 1) + 32'(dig);
  endfunction

  function automatic logic [FRAC_W-1:0] frac_weight(input logic [1:0] pos,
                                                    input logic [3:0] dig);
    logic [FRAC_W-1:0] d;
    d = FRAC_W'(dig);
    case (pos)
      2'd0:    frac_weight = d * FRAC_W'(1000);
      2'd1:    frac_weight = d * FRAC_W'(100);
      2'd2:    frac_weight = d * FRAC_W'(10);
      default: frac_weight = d;
    endcase
  endfunction

endpackage

### sv/serial_command_line_parser.sv
`timescale 1ns / 1ps
// Channel  Direction  Handshake                 Payload
// in       sink       in_valid_i / in_stall_o   func_i, rx_byte_i
// out      source     out_valid_o / out_stall_i status_o .. speed_clamped_o
// cfg      sink       cfg_we_i                  cfg_index_i, cfg_data_i
// One beat per cycle on the input while in_stall_o is low; line parsing updates in the accepting cycle.
// A finished line passes three registers (fraction multiply, sign apply,
// truncate and clamp) before its result reaches the outputs.
// Reset clears the line state, the silence counter and all valid bits.
// in_stall_o rises only while a result is waiting in the first stage and the
// stages behind it are held by out_stall_i.

module serial_command_line_parser (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               func_i,
  input  logic [7:0]         rx_byte_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [2:0]         status_o,
  output logic [7:0]         command_letter_o,
  output logic signed [31:0] address_o,
  output logic signed [47:0] argument_fixed_o,
  output logic signed [31:0] argument_whole_o,
  output logic signed [16:0] speed_value_o,
  output logic               direction_ccw_o,
  output logic               speed_clamped_o,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i
);

  `include "serial_command_line_parser_assert.svh"

  logic [15:0] idle_q, lower_q, upper_q;

  logic [3:0]                    phase_q, phase_d;
  logic [sclp_pkg::CNT_W-1:0]    stored_q, stored_d;
  logic [7:0]                    letter_q, letter_d;
  logic [31:0]                   addr_acc_q, addr_acc_d;
  logic                          addr_neg_q, addr_neg_d;
  logic [31:0]                   whole_q, whole_d;
  logic [sclp_pkg::FRAC_W-1:0]   frac_q, frac_d;
  logic [2:0]                    pos_q, pos_d;
  logic                          arg_neg_q, arg_neg_d;
  logic [15:0]                   silence_q, silence_d;

  logic out_ready, b_ready, a_ready, in_fire;
  logic finish, emit, start_arg, is_digit, is_blank;
  logic [3:0] dig;

  // Stage A
  logic        a_v_q;
  logic [2:0]  a_status_q, a_status;
  logic [7:0]  a_letter_q;
  logic [31:0] a_addr_q, a_addr;
  logic [31:0] a_ip_q;
  logic [15:0] a_fr_q;
  logic        a_neg_q, a_arg_q, a_arg, a_up_q, a_lo_q;
  logic        plain_cmd, arg_cmd;
  logic [sclp_pkg::PROD_W-1:0] frac_prod;

  // Stage B
  logic        b_v_q;
  logic [2:0]  b_status_q;
  logic [7:0]  b_letter_q;
  logic [31:0] b_addr_q;
  logic [48:0] b_fix_q, b_sum, b_fix;
  logic        b_up_q, b_lo_q;

  // Output stage
  logic        out_v_q;
  logic [2:0]  out_status_q;
  logic [7:0]  out_letter_q;
  logic [31:0] out_addr_q, out_whole_q;
  logic [47:0] out_fix_q;
  logic [16:0] out_speed_q, speed;
  logic        out_ccw_q, out_clamp_q, ccw, clamp;
  logic signed [32:0] w33;
  logic signed [31:0] w32, lim32, nlim32;
  logic        w_round, over_hi, under_lo;
  logic [15:0] lim;

  assign out_ready  = !out_v_q || !out_stall_i;
  assign b_ready    = !b_v_q || out_ready;
  assign a_ready    = !a_v_q || b_ready;
  assign in_stall_o = !a_ready;
  assign in_fire    = in_valid_i && a_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_q  <= sclp_pkg::IDLE_FLUSH_RST;
      lower_q <= sclp_pkg::LOWER_LIMIT_RST;
      upper_q <= sclp_pkg::UPPER_LIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        sclp_pkg::CFG_IDLE_FLUSH:  idle_q  <= cfg_data_i;
        sclp_pkg::CFG_LOWER_LIMIT: lower_q <= cfg_data_i;
        sclp_pkg::CFG_UPPER_LIMIT: upper_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign is_digit = rx_byte_i inside {[sclp_pkg::CH_ZERO:sclp_pkg::CH_NINE]};
  assign is_blank = rx_byte_i inside {sclp_pkg::CH_SPACE, sclp_pkg::CH_TAB};
  assign dig      = rx_byte_i[3:0];

  always_comb begin
    phase_d    = phase_q;
    stored_d   = stored_q;
    letter_d   = letter_q;
    addr_acc_d = addr_acc_q;
    addr_neg_d = addr_neg_q;
    whole_d    = whole_q;
    frac_d     = frac_q;
    pos_d      = pos_q;
    arg_neg_d  = arg_neg_q;
    silence_d  = silence_q;
    finish     = 1'b0;
    start_arg  = 1'b0;
    if (in_fire) begin
      if (func_i) begin
        if (silence_q != '1) begin
          silence_d = silence_q + 16'd1;
        end
        finish = (stored_q != '0) && (silence_d > idle_q);
      end else begin
        silence_d = '0;
        if (rx_byte_i == sclp_pkg::CH_CR || rx_byte_i == sclp_pkg::CH_LF) begin
          finish = (stored_q != '0);
        end else if (stored_q < sclp_pkg::CNT_LAST) begin
          stored_d = stored_q + 1'b1;
          case (phase_q)
            sclp_pkg::PH_LEAD: begin
              if (rx_byte_i == sclp_pkg::CH_NUL) begin
                phase_d = sclp_pkg::PH_EMPTY;
              end else if (!is_blank) begin
                letter_d = rx_byte_i;
                phase_d  = (rx_byte_i == sclp_pkg::CH_HELP) ? sclp_pkg::PH_HELP
                                                            : sclp_pkg::PH_ADDR_SP;
              end
            end
            sclp_pkg::PH_ADDR_SP: begin
              if (rx_byte_i == sclp_pkg::CH_MINUS || rx_byte_i == sclp_pkg::CH_PLUS) begin
                addr_neg_d = (rx_byte_i == sclp_pkg::CH_MINUS);
                phase_d    = sclp_pkg::PH_ADDR_SIGN;
              end else if (is_digit) begin
                addr_acc_d = 32'(dig);
                phase_d    = sclp_pkg::PH_ADDR_DIG;
              end else if (!is_blank) begin
                phase_d = sclp_pkg::PH_NOADDR;
              end
            end
            sclp_pkg::PH_ADDR_SIGN: begin
              if (is_digit) begin
                addr_acc_d = 32'(dig);
                phase_d    = sclp_pkg::PH_ADDR_DIG;
              end else begin
                phase_d = sclp_pkg::PH_NOADDR;
              end
            end
            sclp_pkg::PH_ADDR_DIG: begin
              if (is_digit) begin
                addr_acc_d = sclp_pkg::mul10_add(addr_acc_q, dig);
              end else begin
                start_arg = 1'b1;
              end
            end
            sclp_pkg::PH_ARG_SP: begin
              start_arg = 1'b1;
            end
            sclp_pkg::PH_ARG_SIGN: begin
              if (is_digit) begin
                whole_d = 32'(dig);
                phase_d = sclp_pkg::PH_ARG_INT;
              end else begin
                phase_d = sclp_pkg::PH_NOARG;
              end
            end
            sclp_pkg::PH_ARG_INT: begin
              if (is_digit) begin
                whole_d = sclp_pkg::mul10_add(whole_q, dig);
              end else begin
                phase_d = (rx_byte_i == sclp_pkg::CH_DOT) ? sclp_pkg::PH_ARG_FRAC
                                                          : sclp_pkg::PH_ARG_DONE;
              end
            end
            sclp_pkg::PH_ARG_FRAC: begin
              if (is_digit) begin
                if (pos_q < 3'd4) begin
                  frac_d = frac_q + sclp_pkg::frac_weight(pos_q[1:0], dig);
                  pos_d  = pos_q + 3'd1;
                end
              end else begin
                phase_d = sclp_pkg::PH_ARG_DONE;
              end
            end
            default: ;
          endcase
          if (start_arg) begin
            if (is_blank) begin
              phase_d = sclp_pkg::PH_ARG_SP;
            end else if (rx_byte_i == sclp_pkg::CH_MINUS ||
                         rx_byte_i == sclp_pkg::CH_PLUS) begin
              arg_neg_d = (rx_byte_i == sclp_pkg::CH_MINUS);
              phase_d   = sclp_pkg::PH_ARG_SIGN;
            end else if (is_digit) begin
              whole_d = 32'(dig);
              phase_d = sclp_pkg::PH_ARG_INT;
            end else begin
              phase_d = sclp_pkg::PH_NOARG;
            end
          end
        end
      end
      if (finish) begin
        phase_d    = sclp_pkg::PH_LEAD;
        stored_d   = '0;
        letter_d   = '0;
        addr_acc_d = '0;
        addr_neg_d = 1'b0;
        whole_d    = '0;
        frac_d     = '0;
        pos_d      = '0;
        arg_neg_d  = 1'b0;
      end
    end
  end

  assign emit = finish && !(phase_q == sclp_pkg::PH_LEAD || phase_q == sclp_pkg::PH_EMPTY);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= sclp_pkg::PH_LEAD;
      stored_q   <= '0;
      letter_q   <= '0;
      addr_acc_q <= '0;
      addr_neg_q <= 1'b0;
      whole_q    <= '0;
      frac_q     <= '0;
      pos_q      <= '0;
      arg_neg_q  <= 1'b0;
      silence_q  <= '0;
    end else begin
      phase_q    <= phase_d;
      stored_q   <= stored_d;
      letter_q   <= letter_d;
      addr_acc_q <= addr_acc_d;
      addr_neg_q <= addr_neg_d;
      whole_q    <= whole_d;
      frac_q     <= frac_d;
      pos_q      <= pos_d;
      arg_neg_q  <= arg_neg_d;
      silence_q  <= silence_d;
    end
  end

  // Classify the finished line from the line state before it clears.
  assign plain_cmd = letter_q inside {"r", "e", "d", "s", "z", "E", "D", "S", "R"};
  assign arg_cmd   = letter_q inside {"v", "p", "a", "q", "t", "V"};
  assign frac_prod = sclp_pkg::PROD_W'(frac_q) * sclp_pkg::PROD_W'(sclp_pkg::FRAC_RECIP);

  always_comb begin
    a_arg  = 1'b0;
    a_addr = addr_neg_q ? (32'd0 - addr_acc_q) : addr_acc_q;
    if (phase_q == sclp_pkg::PH_HELP) begin
      a_status = sclp_pkg::ST_HELP;
      a_addr   = '0;
    end else if (phase_q inside {sclp_pkg::PH_ADDR_SP, sclp_pkg::PH_ADDR_SIGN,
                                 sclp_pkg::PH_NOADDR}) begin
      a_status = sclp_pkg::ST_MISS_ADDR;
      a_addr   = '0;
    end else if (plain_cmd) begin
      a_status = sclp_pkg::ST_OK;
    end else if (arg_cmd) begin
      if (phase_q inside {sclp_pkg::PH_ARG_INT, sclp_pkg::PH_ARG_FRAC,
                          sclp_pkg::PH_ARG_DONE}) begin
        a_status = sclp_pkg::ST_OK;
        a_arg    = 1'b1;
      end else begin
        a_status = sclp_pkg::ST_MISS_ARG;
      end
    end else begin
      a_status = sclp_pkg::ST_UNKNOWN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
    end else if (a_ready) begin
      a_v_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_ready) begin
      a_status_q <= a_status;
      a_letter_q <= letter_q;
      a_addr_q   <= a_addr;
      a_ip_q     <= whole_q;
      a_fr_q     <= frac_prod[sclp_pkg::FRAC_SHIFT+15:sclp_pkg::FRAC_SHIFT];
      a_neg_q    <= arg_neg_q;
      a_arg_q    <= a_arg;
      a_up_q     <= a_arg && (letter_q == sclp_pkg::CH_UP_V);
      a_lo_q     <= a_arg && (letter_q == sclp_pkg::CH_LO_V);
    end
  end

  // Integer part sits above the 16 fraction bits, so joining them needs no adder.
  assign b_sum = {a_ip_q[31], a_ip_q, a_fr_q};
  assign b_fix = !a_arg_q ? '0 : (a_neg_q ? (49'd0 - b_sum) : b_sum);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_v_q <= 1'b0;
    end else if (b_ready) begin
      b_v_q <= a_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_ready) begin
      b_status_q <= a_status_q;
      b_letter_q <= a_letter_q;
      b_addr_q   <= a_addr_q;
      b_fix_q    <= b_fix;
      b_up_q     <= a_up_q;
      b_lo_q     <= a_lo_q;
    end
  end

  // Truncate toward zero, saturate the top, then clamp the speed.
  assign w_round = b_fix_q[48] && (b_fix_q[15:0] != '0);
  assign w33     = $signed(b_fix_q[48:16]) + $signed({32'd0, w_round});
  assign w32     = (!w33[32] && w33[31]) ? 32'sh7FFF_FFFF : w33[31:0];
  assign lim     = b_up_q ? upper_q : lower_q;
  assign lim32   = $signed({16'd0, lim});
  assign nlim32  = 32'sd0 - lim32;
  assign over_hi  = w32 > lim32;
  assign under_lo = w32 < nlim32;

  always_comb begin
    speed = '0;
    ccw   = 1'b0;
    clamp = 1'b0;
    if (b_up_q) begin
      clamp = over_hi || under_lo;
      if (over_hi) begin
        speed = {1'b0, lim};
      end else if (under_lo) begin
        speed = 17'd0 - {1'b0, lim};
      end else begin
        speed = w32[16:0];
      end
    end else if (b_lo_q) begin
      clamp = over_hi || under_lo;
      ccw   = w32[31];
      if (clamp) begin
        speed = {1'b0, lim};
      end else if (w32[31]) begin
        speed = 17'd0 - w32[16:0];
      end else begin
        speed = w32[16:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_ready) begin
      out_v_q <= b_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready) begin
      out_status_q <= b_status_q;
      out_letter_q <= b_letter_q;
      out_addr_q   <= b_addr_q;
      out_fix_q    <= b_fix_q[47:0];
      out_whole_q  <= w32;
      out_speed_q  <= speed;
      out_ccw_q    <= ccw;
      out_clamp_q  <= clamp;
    end
  end

  assign out_valid_o      = out_v_q;
  assign status_o         = out_status_q;
  assign command_letter_o = out_letter_q;
  assign address_o        = $signed(out_addr_q);
  assign argument_fixed_o = $signed(out_fix_q);
  assign argument_whole_o = $signed(out_whole_q);
  assign speed_value_o    = $signed(out_speed_q);
  assign direction_ccw_o  = out_ccw_q;
  assign speed_clamped_o  = out_clamp_q;

  `SCLP_ASSERT_NEXT(a_line_clears, in_fire && finish, phase_q == sclp_pkg::PH_LEAD && stored_q == '0, "line state not cleared after line end")
  `SCLP_ASSERT_NEXT(a_byte_resets_silence, in_fire && !func_i, silence_q == '0, "silence count not reset by byte")
  `SCLP_ASSERT_IMP(a_no_speed_unless_ok, out_v_q && out_status_q != sclp_pkg::ST_OK, out_speed_q == '0 && !out_ccw_q && !out_clamp_q, "speed fields set on failed command")
  `SCLP_ASSERT_IMP(a_help_zero_fields, out_v_q && out_status_q == sclp_pkg::ST_HELP, out_addr_q == '0 && out_fix_q == '0, "help result carries address or argument")
  `SCLP_ASSERT(a_stored_bound, stored_q <= sclp_pkg::CNT_LAST, "stored count beyond line limit")

endmodule
